[rtl/core/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants for the timer pool scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int TPS_NUM_SLOTS  = 16;   // default pool size
    localparam int TPS_TIME_BITS  = 48;   // default internal time width
    localparam int TPS_IN_TIME_W  = 48;   // time fields on the ports
    localparam int TPS_OP_W       = 3;
    localparam int TPS_KIND_W     = 3;
    localparam int TPS_ID_W       = 4;
    localparam int TPS_MS_SHIFT_W = 10;   // 1000 < 2**10

    typedef enum logic [TPS_OP_W-1:0] {
        OP_RUN_AT    = 3'd0,
        OP_RUN_AFTER = 3'd1,
        OP_RUN_LOOP  = 3'd2,
        OP_CANCEL    = 3'd3,
        OP_TICK      = 3'd4
    } t_tps_op;

    typedef enum logic [TPS_KIND_W-1:0] {
        RSP_ASSIGNED    = 3'd0,
        RSP_POOL_FULL   = 3'd1,
        RSP_CANCELLED   = 3'd2,
        RSP_CANCEL_MISS = 3'd3,
        RSP_FIRED       = 3'd4
    } t_tps_kind;

    typedef struct packed {
        logic [TPS_OP_W-1:0]      op;
        logic [TPS_IN_TIME_W-1:0] now;
        logic [TPS_IN_TIME_W-1:0] time_value;
        logic [TPS_ID_W-1:0]      timer_id;
    } t_tps_cmd;

    typedef struct packed {
        logic [TPS_KIND_W-1:0] kind;
        logic [TPS_ID_W-1:0]   slot_id;
        logic                  last;
    } t_tps_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_ADD,
        S_FREE,
        S_CANCEL,
        S_SCAN,
        S_PICK,
        S_REARM
    } t_tps_state;

    typedef enum logic {
        TU_SCALE,   // saturating ms -> us (times 1000)
        TU_ADD      // saturating add
    } t_tu_mode;

endpackage

[rtl/core/tps_time_unit.sv]
// ----------------------------------------------------------------------------
// tps_time_unit
// Shared saturating time arithmetic: scale by 1000 or add two times.
// ----------------------------------------------------------------------------
module tps_time_unit
    import tps_pkg::*;
#(
    parameter int TIME_BITS = TPS_TIME_BITS
) (
    input  t_tu_mode               i_mode,
    input  logic [TIME_BITS-1:0]   i_a,
    input  logic [TIME_BITS-1:0]   i_b,
    output logic [TIME_BITS-1:0]   o_res
);

    localparam int PW = TIME_BITS + TPS_MS_SHIFT_W;

    logic [PW-1:0]        w_a_ext;
    logic [PW-1:0]        w_prod;
    logic [TIME_BITS:0]   w_sum;

    // 1000 = 1024 - 32 + 8
    assign w_a_ext = PW'(i_a);
    assign w_prod  = (w_a_ext << 10) - (w_a_ext << 5) + (w_a_ext << 3);
    assign w_sum   = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        unique case (i_mode)
            TU_SCALE: begin
                o_res = (|w_prod[PW-1:TIME_BITS]) ? '1 : w_prod[TIME_BITS-1:0];
            end
            TU_ADD: begin
                o_res = w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];
            end
            default: begin
                o_res = '1;
            end
        endcase
    end

endmodule

[rtl/core/timer_pool_scheduler.sv]
// ----------------------------------------------------------------------------
// timer_pool_scheduler
// Pool of one-shot and periodic timer slots with an earliest-first tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; results come
// back on o_rsp, each valid for exactly one cycle while o_valid is high, and
// the receiver must take them as they come. For run_at, a linear walk finds
// the lowest free slot; run_after and run_loop first go through the shared
// scale-by-1000 and saturating add. A tick makes one pass over the expiry
// memory per fired timer plus a final empty pass (one memory read per slot,
// one compare a cycle), and a re-arm step per periodic timer that fires.
// Fired results trail the pass that finds them by one pass, because a
// result is only flagged last once the following pass has come up empty.
// No clearing pass is needed after reset: slot expiry and period stores
// are only read behind a used bit.
// ----------------------------------------------------------------------------
module timer_pool_scheduler
    import tps_pkg::*;
#(
    parameter int NUM_SLOTS = TPS_NUM_SLOTS,
    parameter int TIME_BITS = TPS_TIME_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_tps_cmd i_cmd,
    output logic     o_valid,
    output t_tps_rsp o_rsp
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_W  = $clog2(NUM_SLOTS + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_tps_state             r_state, n_state;
    logic [TPS_OP_W-1:0]    r_op, n_op;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [TIME_BITS-1:0]   r_tv, n_tv;
    logic [TPS_ID_W-1:0]    r_id, n_id;
    logic [TIME_BITS-1:0]   r_acc, n_acc;
    logic [TIME_BITS-1:0]   r_exp_arm, n_exp_arm;
    logic [TIME_BITS-1:0]   r_per_arm, n_per_arm;
    logic                   r_periodic_arm, n_periodic_arm;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_pv, n_pv;
    logic [SLOT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0]      r_best, n_best;
    logic [TIME_BITS-1:0]   r_best_exp, n_best_exp;
    logic                   r_best_vld, n_best_vld;
    logic [SLOT_W-1:0]      r_pend, n_pend;
    logic                   r_pend_vld, n_pend_vld;
    logic [NUM_SLOTS-1:0]   r_used, n_used;
    logic [NUM_SLOTS-1:0]   r_periodic, n_periodic;
    logic [NUM_SLOTS-1:0]   r_done, n_done;
    logic                   r_valid, n_valid;
    t_tps_rsp               r_rsp, n_rsp;

    // Slot stores, read data registered
    logic [TIME_BITS-1:0]   r_exp_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0]   r_per_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0]   r_exp_q;
    logic [TIME_BITS-1:0]   r_per_q;

    logic                   w_we_exp;
    logic                   w_we_per;
    logic [SLOT_W-1:0]      w_wr_addr;
    logic [TIME_BITS-1:0]   w_wr_exp;
    logic [SLOT_W-1:0]      w_rd_addr;

    logic                   w_accept;
    logic [TIME_BITS-1:0]   w_now_in;
    logic [TIME_BITS-1:0]   w_tv_in;
    logic [SLOT_W-1:0]      w_fidx;
    logic                   w_free_hit;
    logic                   w_free_last;
    logic                   w_cancel_hit;
    logic                   w_scan_end;
    logic                   w_cand;

    t_tu_mode               w_tu_mode;
    logic [TIME_BITS-1:0]   w_tu_a;
    logic [TIME_BITS-1:0]   w_tu_b;
    logic [TIME_BITS-1:0]   w_tu_res;

    assign w_accept = start && !busy;

    // Clamp incoming times to the internal time maximum
    generate
        if (TIME_BITS >= TPS_IN_TIME_W) begin : g_wide
            assign w_now_in = TIME_BITS'(i_cmd.now);
            assign w_tv_in  = TIME_BITS'(i_cmd.time_value);
        end else begin : g_narrow
            assign w_now_in = (|i_cmd.now[TPS_IN_TIME_W-1:TIME_BITS])
                            ? '1 : i_cmd.now[TIME_BITS-1:0];
            assign w_tv_in  = (|i_cmd.time_value[TPS_IN_TIME_W-1:TIME_BITS])
                            ? '1 : i_cmd.time_value[TIME_BITS-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Shared arithmetic unit: scale in S_SCALE, add otherwise
    // ------------------------------------------------------------------
    assign w_tu_mode = (r_state == S_SCALE) ? TU_SCALE : TU_ADD;
    assign w_tu_a    = (r_state == S_SCALE) ? r_tv : r_now;
    assign w_tu_b    = (r_state == S_REARM) ? r_per_q : r_acc;

    tps_time_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_time_unit (
        .i_mode (w_tu_mode),
        .i_a    (w_tu_a),
        .i_b    (w_tu_b),
        .o_res  (w_tu_res)
    );

    // ------------------------------------------------------------------
    // Status decodes
    // ------------------------------------------------------------------
    assign w_fidx       = SLOT_W'(r_idx);
    assign w_free_hit   = !r_used[w_fidx];
    assign w_free_last  = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign w_cancel_hit = (32'(r_id) < NUM_SLOTS) && r_used[SLOT_W'(r_id)];
    assign w_scan_end   = (r_idx == IDX_W'(NUM_SLOTS)) && !r_pv;
    // expired, armed and not yet fired in this tick
    assign w_cand       = r_pv && r_used[r_cmp_idx] && !r_done[r_cmp_idx] &&
                          (r_exp_q <= r_now);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd.op) inside
                        OP_RUN_AT:                 n_state = S_FREE;
                        OP_RUN_AFTER, OP_RUN_LOOP: n_state = S_SCALE;
                        OP_CANCEL:                 n_state = S_CANCEL;
                        OP_TICK:                   n_state = S_SCAN;
                        default:                   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCALE:  n_state = S_ADD;
            S_ADD:    n_state = S_FREE;
            S_FREE: begin
                if (w_free_hit || w_free_last) begin
                    n_state = S_IDLE;
                end
            end
            S_CANCEL: n_state = S_IDLE;
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_best_vld) begin
                    n_state = S_IDLE;
                end else if (r_periodic[r_best]) begin
                    n_state = S_REARM;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_REARM:  n_state = S_SCAN;
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_op           = r_op;
        n_now          = r_now;
        n_tv           = r_tv;
        n_id           = r_id;
        n_acc          = r_acc;
        n_exp_arm      = r_exp_arm;
        n_per_arm      = r_per_arm;
        n_periodic_arm = r_periodic_arm;
        n_idx          = r_idx;
        n_pv           = 1'b0;
        n_cmp_idx      = r_cmp_idx;
        n_best         = r_best;
        n_best_exp     = r_best_exp;
        n_best_vld     = r_best_vld;
        n_pend         = r_pend;
        n_pend_vld     = r_pend_vld;
        n_used         = r_used;
        n_periodic     = r_periodic;
        n_done         = r_done;
        n_valid        = 1'b0;
        n_rsp          = r_rsp;
        w_we_exp       = 1'b0;
        w_we_per       = 1'b0;
        w_wr_addr      = w_fidx;
        w_wr_exp       = r_exp_arm;
        w_rd_addr      = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op           = i_cmd.op;
                    n_now          = w_now_in;
                    n_tv           = w_tv_in;
                    n_id           = i_cmd.timer_id;
                    n_exp_arm      = w_tv_in;
                    n_per_arm      = '0;
                    n_periodic_arm = (i_cmd.op == OP_RUN_LOOP);
                    n_idx          = '0;
                    n_best_vld     = 1'b0;
                    n_pend_vld     = 1'b0;
                    n_done         = '0;
                end
            end
            S_SCALE: begin
                n_acc = w_tu_res;
                if (r_op == OP_RUN_LOOP) begin
                    n_per_arm = w_tu_res;
                end
            end
            S_ADD: begin
                n_exp_arm = w_tu_res;
            end
            S_FREE: begin
                if (w_free_hit) begin
                    w_we_exp           = 1'b1;
                    w_we_per           = 1'b1;
                    n_used[w_fidx]     = 1'b1;
                    n_periodic[w_fidx] = r_periodic_arm;
                    n_valid            = 1'b1;
                    n_rsp.kind         = RSP_ASSIGNED;
                    n_rsp.slot_id      = TPS_ID_W'(w_fidx);
                    n_rsp.last         = 1'b1;
                end else if (w_free_last) begin
                    n_valid       = 1'b1;
                    n_rsp.kind    = RSP_POOL_FULL;
                    n_rsp.slot_id = '0;
                    n_rsp.last    = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_CANCEL: begin
                n_valid       = 1'b1;
                n_rsp.slot_id = r_id;
                n_rsp.last    = 1'b1;
                if (w_cancel_hit) begin
                    n_used[SLOT_W'(r_id)]     = 1'b0;
                    n_periodic[SLOT_W'(r_id)] = 1'b0;
                    n_rsp.kind                = RSP_CANCELLED;
                end else begin
                    n_rsp.kind = RSP_CANCEL_MISS;
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare each result in the cycle after its read
                w_rd_addr = w_fidx;
                if (r_idx != IDX_W'(NUM_SLOTS)) begin
                    n_idx     = r_idx + IDX_W'(1);
                    n_pv      = 1'b1;
                    n_cmp_idx = w_fidx;
                end
                // strict less-than keeps the lower slot on a tie
                if (w_cand && (!r_best_vld || (r_exp_q < r_best_exp))) begin
                    n_best     = r_cmp_idx;
                    n_best_exp = r_exp_q;
                    n_best_vld = 1'b1;
                end
            end
            S_PICK: begin
                // period read for r_best is issued here for S_REARM
                if (r_pend_vld) begin
                    n_valid       = 1'b1;
                    n_rsp.kind    = RSP_FIRED;
                    n_rsp.slot_id = TPS_ID_W'(r_pend);
                    n_rsp.last    = !r_best_vld;
                end
                if (r_best_vld) begin
                    n_pend         = r_best;
                    n_pend_vld     = 1'b1;
                    n_done[r_best] = 1'b1;
                    if (!r_periodic[r_best]) begin
                        n_used[r_best] = 1'b0;
                    end
                    n_idx      = '0;
                    n_best_vld = 1'b0;
                end else begin
                    n_pend_vld = 1'b0;
                end
            end
            S_REARM: begin
                w_we_exp  = 1'b1;
                w_wr_addr = r_best;
                w_wr_exp  = w_tu_res;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Slot stores
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we_exp) begin
            r_exp_mem[w_wr_addr] <= w_wr_exp;
        end
        if (w_we_per) begin
            r_per_mem[w_wr_addr] <= r_per_arm;
        end
        r_exp_q <= r_exp_mem[w_rd_addr];
        r_per_q <= r_per_mem[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_periodic <= '0;
            r_done     <= '0;
            r_pv       <= 1'b0;
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_periodic <= n_periodic;
            r_done     <= n_done;
            r_pv       <= n_pv;
            r_best_vld <= n_best_vld;
            r_pend_vld <= n_pend_vld;
            r_valid    <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_now          <= n_now;
        r_tv           <= n_tv;
        r_id           <= n_id;
        r_acc          <= n_acc;
        r_exp_arm      <= n_exp_arm;
        r_per_arm      <= n_per_arm;
        r_periodic_arm <= n_periodic_arm;
        r_idx          <= n_idx;
        r_cmp_idx      <= n_cmp_idx;
        r_best         <= n_best;
        r_best_exp     <= n_best_exp;
        r_pend         <= n_pend;
        r_rsp          <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_pend_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !r_pend_vld)
        else $error("fired result still pending at new transaction");

    a_scan_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= IDX_W'(NUM_SLOTS)))
        else $error("scan index ran past the pool");

    a_fired_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.kind == RSP_FIRED)) |-> ($past(r_state) == S_PICK))
        else $error("fired result outside of a tick");

    a_single_rsp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.kind != RSP_FIRED)) |-> o_rsp.last)
        else $error("request result not flagged last");

    a_rearm_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REARM) |-> (r_done[r_best] && r_used[r_best] && r_periodic[r_best]))
        else $error("re-arm of a slot that did not just fire");

endmodule
